@@ hw/rtl/midi_note_event_encoder_macros.svh @@
// ----------------------------------------------------------------------------
// MIDI note event encoder assertion macros
// Shared concurrent assertion forms, clocked and gated by the synchronous reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_EVENT_ENCODER_MACROS_SVH
`define MIDI_NOTE_EVENT_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MNEE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("midi_note_event_encoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MNEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("midi_note_event_encoder: next-cycle check failed");

`endif

@@ hw/rtl/mnee_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI note event encoder package
// Fixed widths and byte codes of the MIDI note event stream.
// ----------------------------------------------------------------------------
package mnee_pkg;

    localparam int unsigned BPM_W   = 10;
    localparam int unsigned DIV_W   = 26;   // wide enough for 60000000
    localparam int unsigned TICK_W  = 28;   // four seven-bit groups
    localparam int unsigned DUR_W   = 32;

    localparam logic [BPM_W-1:0]  TEMPO_RESET   = 10'd120;
    localparam logic [DIV_W-1:0]  US_PER_MINUTE = 26'd60000000;
    localparam logic [TICK_W-1:0] TICK_LIMIT    = 28'hFFFFFFF;

    localparam logic [7:0] NOTE_ON     = 8'h90;
    localparam logic [7:0] NOTE_OFF    = 8'h80;
    localparam logic [7:0] RELEASE_VEL = 8'd64;
    localparam logic [7:0] DELTA_ZERO  = 8'h00;

    typedef logic [BPM_W-1:0]  t_bpm;
    typedef logic [DIV_W-1:0]  t_div;
    typedef logic [TICK_W-1:0] t_ticks;

endpackage

@@ hw/rtl/midi_note_event_encoder.sv @@
// ----------------------------------------------------------------------------
// MIDI note event encoder: note in, note-on / length / note-off bytes out.
// After accept, the shared serial divider works out the beat length, then the ticks, at one
// quotient bit per cycle; the bytes then follow at one byte/cycle while the receiver is ready.
// A new note is taken only in idle, once the last byte of the previous note is loaded.
// Reset: synchronous, active low; tempo returns to 120 bpm, no byte pending.
// ----------------------------------------------------------------------------
`include "midi_note_event_encoder_macros.svh"

module midi_note_event_encoder #(
    parameter int unsigned TICKS_PER_BEAT = 240
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // note input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_key,
    input  logic [6:0]  i_velocity,
    input  logic [31:0] i_duration_us,
    // byte output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);

    localparam int unsigned TPB_W  = $clog2(TICKS_PER_BEAT + 1);
    localparam int unsigned PROD_W = mnee_pkg::DUR_W + TPB_W;
    localparam int unsigned CNT_W  = $clog2(PROD_W);
    localparam int unsigned DIV_W  = mnee_pkg::DIV_W;
    localparam int unsigned TICK_W = mnee_pkg::TICK_W;
    localparam logic [TPB_W-1:0] TPB = TPB_W'(TICKS_PER_BEAT);
    localparam logic [CNT_W-1:0] TEMPO_LAST = CNT_W'(DIV_W - 1);
    localparam logic [CNT_W-1:0] TICKS_LAST = CNT_W'(PROD_W - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TEMPO = 2'd1;
    localparam logic [1:0] ST_TICKS = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam logic [2:0] B_DELTA = 3'd0;
    localparam logic [2:0] B_ON    = 3'd1;
    localparam logic [2:0] B_KEY   = 3'd2;
    localparam logic [2:0] B_VEL   = 3'd3;
    localparam logic [2:0] B_LEN   = 3'd4;
    localparam logic [2:0] B_OFF   = 3'd5;
    localparam logic [2:0] B_KEY2  = 3'd6;
    localparam logic [2:0] B_REL   = 3'd7;

    logic                 w_tempo_wr;
    mnee_pkg::t_bpm       r_tempo;
    logic [1:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [PROD_W-1:0]    r_dq, n_dq;
    mnee_pkg::t_div       r_div, n_div;
    logic [3:0]           r_chan;
    logic [6:0]           r_key;
    logic [6:0]           r_vel;
    logic [31:0]          r_dur;
    mnee_pkg::t_ticks     r_ticks, n_ticks;
    logic [1:0]           r_grp, n_grp;
    logic [2:0]           r_idx, n_idx;
    logic                 r_ovalid, n_ovalid;
    logic [7:0]           r_obyte, n_obyte;
    logic                 r_olast, n_olast;

    logic                 w_in_acc;
    logic                 w_load;
    logic [DIV_W:0]       w_shift;
    logic                 w_ge;
    logic [DIV_W:0]       w_diff;
    logic [DIV_W-1:0]     w_rem_step;
    logic [PROD_W-1:0]    w_dq_step;
    logic [PROD_W-1:0]    w_prod;
    mnee_pkg::t_ticks     w_ticks;
    logic [6:0]           w_group;

    // Configuration
    assign pready     = 1'b1;
    assign w_tempo_wr = psel && penable && pwrite && !paddr[2];
    assign prdata     = paddr[2] ? 32'd0 : 32'(r_tempo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo <= mnee_pkg::TEMPO_RESET;
        end else if (w_tempo_wr) begin
            r_tempo <= pwdata[mnee_pkg::BPM_W-1:0];
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // One restoring-division step: one quotient bit enters the low end of r_dq
    // while the dividend leaves at the top into the partial remainder.
    assign w_shift    = {r_rem, r_dq[PROD_W-1]};
    assign w_diff     = w_shift - {1'b0, r_div};
    assign w_ge       = (w_shift >= {1'b0, r_div});
    assign w_rem_step = w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
    assign w_dq_step  = {r_dq[PROD_W-2:0], w_ge};

    assign w_prod  = {{TPB_W{1'b0}}, r_dur} * {{mnee_pkg::DUR_W{1'b0}}, TPB};
    assign w_ticks = (|w_dq_step[PROD_W-1:TICK_W]) ? mnee_pkg::TICK_LIMIT
                                                    : w_dq_step[TICK_W-1:0];

    always_comb begin
        case (r_grp)
            2'd0:    w_group = r_ticks[6:0];
            2'd1:    w_group = r_ticks[13:7];
            2'd2:    w_group = r_ticks[20:14];
            default: w_group = r_ticks[27:21];
        endcase
    end

    assign w_load = (r_state == ST_OUT) && (!r_ovalid || i_out_ready);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_dq     = r_dq;
        n_div    = r_div;
        n_ticks  = r_ticks;
        n_grp    = r_grp;
        n_idx    = r_idx;
        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_olast  = r_olast;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_TEMPO;
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_dq    = {mnee_pkg::US_PER_MINUTE, {(PROD_W-DIV_W){1'b0}}};
                    // A zero tempo is taken as one beat per minute.
                    n_div   = (r_tempo == '0) ? DIV_W'(1) : DIV_W'(r_tempo);
                end
            end
            ST_TEMPO: begin
                n_rem = w_rem_step;
                n_dq  = w_dq_step;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == TEMPO_LAST) begin
                    n_state = ST_TICKS;
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_div   = w_dq_step[DIV_W-1:0];
                    n_dq    = w_prod;
                end
            end
            ST_TICKS: begin
                n_rem = w_rem_step;
                n_dq  = w_dq_step;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == TICKS_LAST) begin
                    n_state = ST_OUT;
                    n_idx   = B_DELTA;
                    n_ticks = w_ticks;
                    if (w_ticks[27:21] != '0) begin
                        n_grp = 2'd3;
                    end else if (w_ticks[20:14] != '0) begin
                        n_grp = 2'd2;
                    end else if (w_ticks[13:7] != '0) begin
                        n_grp = 2'd1;
                    end else begin
                        n_grp = 2'd0;
                    end
                end
            end
            ST_OUT: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_olast  = 1'b0;
                    n_idx    = r_idx + 1'b1;
                    case (r_idx)
                        B_DELTA: n_obyte = mnee_pkg::DELTA_ZERO;
                        B_ON:    n_obyte = mnee_pkg::NOTE_ON | {4'd0, r_chan};
                        B_KEY:   n_obyte = {1'b0, r_key};
                        B_VEL:   n_obyte = {1'b0, r_vel};
                        B_LEN: begin
                            // Most significant group first; continuation bit on all
                            // groups but the lowest.
                            n_obyte = {(r_grp != 2'd0), w_group};
                            if (r_grp != 2'd0) begin
                                n_idx = B_LEN;
                                n_grp = r_grp - 1'b1;
                            end
                        end
                        B_OFF:   n_obyte = mnee_pkg::NOTE_OFF | {4'd0, r_chan};
                        B_KEY2:  n_obyte = {1'b0, r_key};
                        default: begin
                            n_obyte = mnee_pkg::RELEASE_VEL;
                            n_olast = 1'b1;
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_dq    <= n_dq;
        r_div   <= n_div;
        r_ticks <= n_ticks;
        r_grp   <= n_grp;
        r_idx   <= n_idx;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        if (w_in_acc) begin
            r_chan <= i_channel;
            r_key  <= i_key;
            r_vel  <= i_velocity;
            r_dur  <= i_duration_us;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_last_byte = r_olast;

    // A note that has been taken starts with the beat-length division.
    `MNEE_ASSERT_NEXT(a_accept_starts_div, i_clk, i_rst_n, w_in_acc,
                      (r_state == ST_TEMPO) && (r_cnt == '0))
    // The partial remainder never reaches the divisor while dividing.
    `MNEE_ASSERT_SAME(a_rem_below_div, i_clk, i_rst_n,
                      (r_state == ST_TEMPO) || (r_state == ST_TICKS), r_rem < r_div)
    // The final byte of a note is always the release velocity.
    `MNEE_ASSERT_SAME(a_last_is_release, i_clk, i_rst_n, r_ovalid && r_olast,
                      r_obyte == mnee_pkg::RELEASE_VEL)
    // Once the final byte is taken, nothing follows until the next note is divided.
    `MNEE_ASSERT_NEXT(a_no_byte_after_last, i_clk, i_rst_n,
                      r_ovalid && r_olast && i_out_ready, !r_ovalid)

endmodule

@@ tb/sv/midi_note_stream_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note stream checker
// Follows the tempo register through the configuration port, works out the
// byte stream of every accepted note and compares each accepted output byte
// with the oldest byte still outstanding.
// ----------------------------------------------------------------------------
module midi_note_stream_checker #(
    parameter int unsigned TICKS_PER_BEAT = 240,
    parameter logic [2:0]  TEMPO_ADDR     = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_key,
    input  logic [6:0]  i_velocity,
    input  logic [31:0] i_duration_us,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_byte,
    input  logic        i_last_byte,
    output int          o_error_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_stream_byte;

    t_stream_byte   expected_bytes[$];
    mnee_pkg::t_bpm tempo_bpm;
    int             error_count = 0;
    int             pending     = 0;

    assign o_error_count = error_count;
    assign o_pending     = pending;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void push_byte(input logic [7:0] value, input logic last);
        t_stream_byte b;
        b.value = value;
        b.last  = last;
        expected_bytes.push_back(b);
    endfunction

    // Beat length first, then the tick count from the exact 64-bit product.
    function automatic void encode_note(input logic [3:0] channel, input logic [6:0] key,
                                        input logic [6:0] velocity, input logic [31:0] dur);
        logic [63:0] bpm;
        logic [63:0] us_per_beat;
        logic [63:0] ticks;
        logic [7:0]  group_byte;
        int          groups;
        bpm = (tempo_bpm == '0) ? 64'd1 : 64'(tempo_bpm);
        us_per_beat = 64'(mnee_pkg::US_PER_MINUTE) / bpm;
        ticks = (64'(TICKS_PER_BEAT) * 64'(dur)) / us_per_beat;
        if (ticks > 64'(mnee_pkg::TICK_LIMIT)) begin
            ticks = 64'(mnee_pkg::TICK_LIMIT);
        end
        push_byte(mnee_pkg::DELTA_ZERO, 1'b0);
        push_byte(mnee_pkg::NOTE_ON + {4'd0, channel}, 1'b0);
        push_byte({1'b0, key}, 1'b0);
        push_byte({1'b0, velocity}, 1'b0);
        groups = 1;
        while (groups < 4 && (ticks >> (7 * groups)) != 0) begin
            groups++;
        end
        for (int g = groups - 1; g >= 0; g--) begin
            group_byte = {1'b0, 7'(ticks >> (7 * g))};
            if (g != 0) begin
                group_byte[7] = 1'b1;
            end
            push_byte(group_byte, 1'b0);
        end
        push_byte(mnee_pkg::NOTE_OFF + {4'd0, channel}, 1'b0);
        push_byte({1'b0, key}, 1'b0);
        push_byte(mnee_pkg::RELEASE_VEL, 1'b1);
    endfunction

    always @(posedge i_clk) begin
        t_stream_byte want;
        if (!i_rst_n) begin
            tempo_bpm = mnee_pkg::TEMPO_RESET;
            expected_bytes.delete();
        end else begin
            // Writes to any other address leave the tempo alone.
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == TEMPO_ADDR) begin
                tempo_bpm = i_pwdata[mnee_pkg::BPM_W-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte 0x%02h last %0b",
                                              i_out_byte, i_last_byte));
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_byte !== want.value) begin
                        report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                                  i_out_byte, want.value));
                    end
                    if (i_last_byte !== want.last) begin
                        report_mismatch($sformatf("last_byte %0b, expected %0b on byte 0x%02h",
                                                  i_last_byte, want.last, want.value));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                encode_note(i_channel, i_key, i_velocity, i_duration_us);
            end
        end
        pending = expected_bytes.size();
    end

endmodule

@@ tb/sv/midi_note_event_encoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note event encoder testbench
// Drives notes and tempo settings into the encoder under random idling and
// back-pressure; a separate checker predicts and compares every output byte.
// ----------------------------------------------------------------------------
module midi_note_event_encoder_tb;

    localparam int unsigned TICKS_PER_BEAT = 240;
    localparam logic [2:0]  ADDR_TEMPO     = 3'd0;
    localparam logic [2:0]  ADDR_SPARE     = 3'd4;   // no register behind it
    localparam int          HOLD_CYCLES    = 400;
    localparam int          RANDOM_PHASE   = 31;

    typedef struct {
        logic [3:0]  channel;
        logic [6:0]  key;
        logic [6:0]  velocity;
        logic [31:0] duration_us;
    } t_note;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [3:0]  i_channel;
    logic [6:0]  i_key;
    logic [6:0]  i_velocity;
    logic [31:0] i_duration_us;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;

    int             error_count;
    int             bytes_pending;
    bit             no_idle       = 1'b0;
    int             hold_requests = 0;
    mnee_pkg::t_bpm cur_bpm       = mnee_pkg::TEMPO_RESET;

    // Tick counts on either side of each change in the length's byte count.
    longint unsigned vlq_edges[6] = '{127, 128, 16383, 16384, 2097151, 2097152};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    midi_note_event_encoder #(
        .TICKS_PER_BEAT(TICKS_PER_BEAT)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_channel     (i_channel),
        .i_key         (i_key),
        .i_velocity    (i_velocity),
        .i_duration_us (i_duration_us),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_byte   (o_last_byte)
    );

    midi_note_stream_checker #(
        .TICKS_PER_BEAT(TICKS_PER_BEAT),
        .TEMPO_ADDR    (ADDR_TEMPO)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_channel     (i_channel),
        .i_key         (i_key),
        .i_velocity    (i_velocity),
        .i_duration_us (i_duration_us),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_byte    (o_out_byte),
        .i_last_byte   (o_last_byte),
        .o_error_count (error_count),
        .o_pending     (bytes_pending)
    );

    // Shortest duration that gives the wanted tick count at the given tempo.
    function automatic logic [31:0] duration_for_ticks(input longint unsigned ticks,
                                                       input mnee_pkg::t_bpm bpm);
        longint unsigned us_per_beat;
        longint unsigned dur;
        us_per_beat = 64'(mnee_pkg::US_PER_MINUTE) / ((bpm == '0) ? 64'd1 : 64'(bpm));
        dur = (ticks * us_per_beat + TICKS_PER_BEAT - 1) / TICKS_PER_BEAT;
        return (dur > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dur[31:0];
    endfunction

    function automatic t_note make_note(input logic [3:0] channel, input logic [6:0] key,
                                        input logic [6:0] velocity, input logic [31:0] dur);
        t_note n;
        n.channel     = channel;
        n.key         = key;
        n.velocity    = velocity;
        n.duration_us = dur;
        return n;
    endfunction

    function automatic t_note random_note();
        logic [31:0] dur;
        case ($urandom_range(0, 3))
            0: dur = $urandom();
            1: dur = $urandom_range(0, 5000000);
            2: dur = duration_for_ticks(vlq_edges[$urandom_range(0, 5)]
                                        + $urandom_range(0, 2) - 1, cur_bpm);
            default: dur = $urandom_range(0, 3000);
        endcase
        return make_note(4'($urandom()), 7'($urandom()), 7'($urandom()), dur);
    endfunction

    task automatic send_note(input t_note n);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 15) begin
            i_in_valid    <= 1'b0;
            i_channel     <= 4'($urandom());
            i_key         <= 7'($urandom());
            i_velocity    <= 7'($urandom());
            i_duration_us <= $urandom();
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_channel     <= n.channel;
        i_key         <= n.key;
        i_velocity    <= n.velocity;
        i_duration_us <= n.duration_us;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Lowers valid after the last transaction and waits for every byte.
    task automatic drain_stream();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (bytes_pending == 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TEMPO) begin
            cur_bpm = data[mnee_pkg::BPM_W-1:0];
        end
    endtask

    task automatic set_tempo(input mnee_pkg::t_bpm bpm);
        write_reg(ADDR_TEMPO, {22'($urandom_range(0, 32'h3F_FFFF)), bpm});
    endtask

    task automatic random_phase(input int count, input bit with_hold, input bit mid_pause);
        for (int i = 0; i < count; i++) begin
            // A long receiver stall while notes keep coming fills the block.
            if (with_hold && i == 5) begin
                hold_requests++;
            end
            if (mid_pause && i == count / 2) begin
                drain_stream();
            end
            send_note(random_note());
        end
        drain_stream();
    endtask

    // Receiver: random stalls, a quiet stretch, and long hold-offs on request.
    initial begin
        int served;
        served      = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests > served) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                served++;
            end else if (no_idle) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= 15);
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_channel     = '0;
        i_key         = '0;
        i_velocity    = '0;
        i_duration_us = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset tempo: field extremes and the one-, two- and three-byte lengths.
        send_note(make_note(4'd0, 7'd0, 7'd0, 32'd0));
        send_note(make_note(4'd15, 7'd127, 7'd127, 32'hFFFF_FFFF));
        send_note(make_note(4'd5, 7'd60, 7'd100, 32'd1));
        send_note(make_note(4'd15, 7'd0, 7'd127, duration_for_ticks(127, cur_bpm)));
        send_note(make_note(4'd0, 7'd127, 7'd0, duration_for_ticks(128, cur_bpm)));
        send_note(make_note(4'd10, 7'd85, 7'd42, duration_for_ticks(16383, cur_bpm)));
        send_note(make_note(4'd5, 7'd42, 7'd85, duration_for_ticks(16384, cur_bpm)));
        drain_stream();

        // Fast tempo reaches the four-byte length.
        set_tempo(10'd1000);
        send_note(make_note(4'd9, 7'd36, 7'd127, duration_for_ticks(2097151, cur_bpm)));
        send_note(make_note(4'd9, 7'd38, 7'd1, duration_for_ticks(2097152, cur_bpm)));
        send_note(make_note(4'd3, 7'd64, 7'd64, 32'hFFFF_FFFF));
        drain_stream();

        // Zero tempo is taken as one beat per minute.
        set_tempo(10'd0);
        send_note(make_note(4'd15, 7'd127, 7'd127, 32'hFFFF_FFFF));
        send_note(make_note(4'd1, 7'd1, 7'd1, 32'd249999));
        send_note(make_note(4'd2, 7'd2, 7'd2, 32'd250000));
        drain_stream();

        // Tempo above the usual range is used as written.
        set_tempo(10'd1023);
        send_note(make_note(4'd7, 7'd99, 7'd33, 32'hFFFF_FFFF));
        send_note(make_note(4'd8, 7'd11, 7'd77, duration_for_ticks(2097152, cur_bpm)));
        drain_stream();

        // A write to an address with no register must not touch the tempo.
        write_reg(ADDR_SPARE, $urandom());
        send_note(make_note(4'd12, 7'd120, 7'd90, 32'hFFFF_FFFF));
        drain_stream();

        set_tempo(mnee_pkg::TEMPO_RESET);
        random_phase(RANDOM_PHASE, 1'b1, 1'b0);
        set_tempo(10'd1);
        random_phase(RANDOM_PHASE, 1'b0, 1'b1);
        set_tempo(10'd1000);
        no_idle = 1'b1;
        random_phase(RANDOM_PHASE, 1'b0, 1'b0);
        no_idle = 1'b0;
        set_tempo(10'd0);
        random_phase(RANDOM_PHASE, 1'b0, 1'b0);
        set_tempo(10'($urandom_range(1001, 1023)));
        random_phase(RANDOM_PHASE, 1'b1, 1'b0);
        write_reg(ADDR_SPARE, $urandom());
        set_tempo(10'($urandom_range(2, 999)));
        random_phase(RANDOM_PHASE, 1'b0, 1'b0);

        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
